/* sv/mouse_packet_cursor_tracker_macros.svh */
// Assertion macros shared by the cursor tracker RTL.
`ifndef MOUSE_PACKET_CURSOR_TRACKER_MACROS_SVH
`define MOUSE_PACKET_CURSOR_TRACKER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that cons holds in the same cycle as ante.
`define MPCT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mpct assertion failed");

// Check that cons holds in the cycle after ante.
`define MPCT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mpct assertion failed");

`else

`define MPCT_ASSERT_SAME(lbl, ante, cons)
`define MPCT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* sv/mpct_pkg.sv */
// Types and constants of the mouse packet cursor tracker.
`default_nettype none

package mpct_pkg;

    // Width of the kept cursor coordinates and of the limit registers
    localparam int COORD_BITS = 12;
    // Fixed widths of the item fields
    localparam int CURSOR_BITS = 12;
    localparam int BYTE_BITS = 8;
    localparam int BUTTON_BITS = 3;
    localparam int DELTA_BITS = BYTE_BITS + 1;
    // Sum width: coordinate plus sign plus one bit of headroom
    localparam int SUM_BITS = COORD_BITS + 2;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 1;
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MAX_X = 1'b0,
        REG_MAX_Y = 1'b1
    } cfg_reg_t;

    // Header byte fields
    localparam logic [BYTE_BITS-1:0] HDR_CHECK_MASK  = 8'hC8;
    localparam logic [BYTE_BITS-1:0] HDR_CHECK_VALUE = 8'h08;
    localparam int HDR_SIGN_X_BIT = 4;
    localparam int HDR_SIGN_Y_BIT = 5;

    // Reset values
    localparam int MAX_X_RESET_VAL = 1279;
    localparam int MAX_Y_RESET_VAL = 719;
    localparam logic [COORD_BITS-1:0] MAX_X_RESET = COORD_BITS'(MAX_X_RESET_VAL);
    localparam logic [COORD_BITS-1:0] MAX_Y_RESET = COORD_BITS'(MAX_Y_RESET_VAL);
    localparam logic [COORD_BITS-1:0] POS_X_RESET = COORD_BITS'(MAX_X_RESET_VAL / 2);
    localparam logic [COORD_BITS-1:0] POS_Y_RESET = COORD_BITS'(MAX_Y_RESET_VAL / 2);

    // Outcome of one packet, from the update logic to the top level
    typedef struct packed {
        logic                   emit;
        logic [COORD_BITS-1:0]  pos_x;
        logic [COORD_BITS-1:0]  pos_y;
        logic [BUTTON_BITS-1:0] buttons;
        logic [BUTTON_BITS-1:0] changed;
        logic                   moved;
    } update_t;

endpackage

`default_nettype wire

/* sv/mpct_packet_if.sv */
// Channel interfaces: mouse packets in, cursor events out.
`default_nettype none

interface mpct_packet_if;
    logic                              valid;
    logic                              ready;
    logic [mpct_pkg::BYTE_BITS-1:0]    header_byte;
    logic [mpct_pkg::BYTE_BITS-1:0]    delta_x_byte;
    logic [mpct_pkg::BYTE_BITS-1:0]    delta_y_byte;

    modport source (output valid, output header_byte, output delta_x_byte,
                    output delta_y_byte, input ready);
    modport sink (input valid, input header_byte, input delta_x_byte,
                  input delta_y_byte, output ready);
endinterface

interface mpct_cursor_if;
    logic                              valid;
    logic                              ready;
    logic [mpct_pkg::CURSOR_BITS-1:0]  cursor_x;
    logic [mpct_pkg::CURSOR_BITS-1:0]  cursor_y;
    logic [mpct_pkg::BUTTON_BITS-1:0]  button_state;
    logic [mpct_pkg::BUTTON_BITS-1:0]  button_changed;
    logic                              moved;

    modport source (output valid, output cursor_x, output cursor_y, output button_state,
                    output button_changed, output moved, input ready);
    modport sink (input valid, input cursor_x, input cursor_y, input button_state,
                  input button_changed, input moved, output ready);
endinterface

`default_nettype wire

/* sv/mpct_update.sv */
// Packet decode, cursor add, clamp and change detection for one item.
`default_nettype none

module mpct_update (
    input  wire logic [mpct_pkg::BYTE_BITS-1:0]   header_byte,
    input  wire logic [mpct_pkg::BYTE_BITS-1:0]   delta_x_byte,
    input  wire logic [mpct_pkg::BYTE_BITS-1:0]   delta_y_byte,
    input  wire logic [mpct_pkg::COORD_BITS-1:0]  pos_x,
    input  wire logic [mpct_pkg::COORD_BITS-1:0]  pos_y,
    input  wire logic [mpct_pkg::BUTTON_BITS-1:0] last_buttons,
    input  wire logic [mpct_pkg::COORD_BITS-1:0]  max_x,
    input  wire logic [mpct_pkg::COORD_BITS-1:0]  max_y,
    output mpct_pkg::update_t                     result
);

    logic                                       header_ok;
    logic signed [mpct_pkg::DELTA_BITS-1:0]     dx;
    logic signed [mpct_pkg::DELTA_BITS-1:0]     dy;
    logic signed [mpct_pkg::SUM_BITS-1:0]       sum_x;
    logic signed [mpct_pkg::SUM_BITS-1:0]       sum_y;
    logic [mpct_pkg::COORD_BITS-1:0]            new_x;
    logic [mpct_pkg::COORD_BITS-1:0]            new_y;
    logic [mpct_pkg::BUTTON_BITS-1:0]           buttons;
    logic                                       moved;

    // Check the sync bit and the overflow bits
    assign header_ok = (header_byte & mpct_pkg::HDR_CHECK_MASK) == mpct_pkg::HDR_CHECK_VALUE;

    // Extend the movement bytes to nine-bit deltas
    assign dx = {header_byte[mpct_pkg::HDR_SIGN_X_BIT], delta_x_byte};
    assign dy = {header_byte[mpct_pkg::HDR_SIGN_Y_BIT], delta_y_byte};
    assign buttons = header_byte[mpct_pkg::BUTTON_BITS-1:0];

    // Add X, subtract Y (screen Y grows downward)
    assign sum_x = $signed({2'b00, pos_x}) + mpct_pkg::SUM_BITS'(dx);
    assign sum_y = $signed({2'b00, pos_y}) - mpct_pkg::SUM_BITS'(dy);

    // Clamp both coordinates into 0..max
    always_comb
    begin
        if (sum_x[mpct_pkg::SUM_BITS-1])
        begin
            new_x = '0;
        end
        else if (sum_x[mpct_pkg::SUM_BITS-2:0] > {1'b0, max_x})
        begin
            new_x = max_x;
        end
        else
        begin
            new_x = sum_x[mpct_pkg::COORD_BITS-1:0];
        end

        if (sum_y[mpct_pkg::SUM_BITS-1])
        begin
            new_y = '0;
        end
        else if (sum_y[mpct_pkg::SUM_BITS-2:0] > {1'b0, max_y})
        begin
            new_y = max_y;
        end
        else
        begin
            new_y = sum_y[mpct_pkg::COORD_BITS-1:0];
        end
    end

    // Emit only for a good header when position or buttons change
    assign moved = (new_x != pos_x) || (new_y != pos_y);

    assign result.emit    = header_ok && (moved || (buttons != last_buttons));
    assign result.pos_x   = new_x;
    assign result.pos_y   = new_y;
    assign result.buttons = buttons;
    assign result.changed = buttons ^ last_buttons;
    assign result.moved   = moved;

endmodule

`default_nettype wire

/* sv/mouse_packet_cursor_tracker.sv */
// Mouse packet cursor tracker: top level.
//
// packet channel (sink): one item is one three-byte mouse packet. Packets with a
// bad header (overflow bits set or sync bit clear) are dropped without effect.
// cursor channel (source): one item per packet that moves the cursor or changes
// the buttons; packets that change nothing give no item.
// Configuration: cfg_write with cfg_index selects max_x (0) or max_y (1); write
// only while no packet is in flight. The clamp applies from the next packet on.
// Path: a taken packet passes the input register, then the output register, on its
// way to the cursor port. Throughput: one packet per cycle while the cursor channel
// does not stall, set by the add-and-clamp path between the input register and the
// output register, which also updates the kept position.
// Reset: limits go to 1279 and 719, the cursor to 639,359, buttons to zero, and
// both channels empty.
// Stall: a waiting event holds in the output register; the input register still
// takes one more packet and holds it until the output register frees up.
`default_nettype none

`include "mouse_packet_cursor_tracker_macros.svh"

module mouse_packet_cursor_tracker (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    mpct_packet_if.sink                                  packet,
    mpct_cursor_if.source                                cursor,
    input  wire logic                                    cfg_write,
    input  wire logic [mpct_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [mpct_pkg::COORD_BITS-1:0]         cfg_data
);

    // Input register
    logic                                stage_valid_reg;
    logic [mpct_pkg::BYTE_BITS-1:0]      header_reg;
    logic [mpct_pkg::BYTE_BITS-1:0]      delta_x_reg;
    logic [mpct_pkg::BYTE_BITS-1:0]      delta_y_reg;

    // Kept state and limits
    logic [mpct_pkg::COORD_BITS-1:0]     pos_x_reg;
    logic [mpct_pkg::COORD_BITS-1:0]     pos_y_reg;
    logic [mpct_pkg::BUTTON_BITS-1:0]    last_buttons_reg;
    logic [mpct_pkg::COORD_BITS-1:0]     max_x_reg;
    logic [mpct_pkg::COORD_BITS-1:0]     max_y_reg;

    // Output register
    logic                                out_valid_reg;
    logic [mpct_pkg::CURSOR_BITS-1:0]    out_x_reg;
    logic [mpct_pkg::CURSOR_BITS-1:0]    out_y_reg;
    logic [mpct_pkg::BUTTON_BITS-1:0]    out_buttons_reg;
    logic [mpct_pkg::BUTTON_BITS-1:0]    out_changed_reg;
    logic                                out_moved_reg;

    logic                                advance;
    logic                                commit;
    logic                                out_valid_next;
    mpct_pkg::update_t                   upd;

    // Advance the input register whenever the output register is free or drains
    assign advance        = !out_valid_reg || cursor.ready;
    assign packet.ready   = !stage_valid_reg || advance;
    assign commit         = stage_valid_reg && advance && upd.emit;
    assign out_valid_next = advance ? (stage_valid_reg && upd.emit) : out_valid_reg;

    mpct_update u_update (
        .header_byte  (header_reg),
        .delta_x_byte (delta_x_reg),
        .delta_y_byte (delta_y_reg),
        .pos_x        (pos_x_reg),
        .pos_y        (pos_y_reg),
        .last_buttons (last_buttons_reg),
        .max_x        (max_x_reg),
        .max_y        (max_y_reg),
        .result       (upd)
    );

    // Control state, kept cursor and limits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
            pos_x_reg        <= mpct_pkg::POS_X_RESET;
            pos_y_reg        <= mpct_pkg::POS_Y_RESET;
            last_buttons_reg <= '0;
            max_x_reg        <= mpct_pkg::MAX_X_RESET;
            max_y_reg        <= mpct_pkg::MAX_Y_RESET;
        end
        else
        begin
            if (packet.ready)
            begin
                stage_valid_reg <= packet.valid;
            end
            out_valid_reg <= out_valid_next;
            if (commit)
            begin
                pos_x_reg        <= upd.pos_x;
                pos_y_reg        <= upd.pos_y;
                last_buttons_reg <= upd.buttons;
            end
            // Decode configuration writes
            if (cfg_write)
            begin
                unique case (mpct_pkg::cfg_reg_t'(cfg_index))
                    mpct_pkg::REG_MAX_X: max_x_reg <= cfg_data;
                    mpct_pkg::REG_MAX_Y: max_y_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Capture packet payload
    always_ff @(posedge clk)
    begin
        if (packet.valid && packet.ready)
        begin
            header_reg  <= packet.header_byte;
            delta_x_reg <= packet.delta_x_byte;
            delta_y_reg <= packet.delta_y_byte;
        end
    end

    // Capture event payload
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_x_reg       <= mpct_pkg::CURSOR_BITS'(upd.pos_x);
            out_y_reg       <= mpct_pkg::CURSOR_BITS'(upd.pos_y);
            out_buttons_reg <= upd.buttons;
            out_changed_reg <= upd.changed;
            out_moved_reg   <= upd.moved;
        end
    end

    assign cursor.valid          = out_valid_reg;
    assign cursor.cursor_x       = out_x_reg;
    assign cursor.cursor_y       = out_y_reg;
    assign cursor.button_state   = out_buttons_reg;
    assign cursor.button_changed = out_changed_reg;
    assign cursor.moved          = out_moved_reg;

    // A waiting event always reflects the kept state
    `MPCT_ASSERT_SAME(a_event_matches_state, out_valid_reg, (out_x_reg == mpct_pkg::CURSOR_BITS'(pos_x_reg)) && (out_y_reg == mpct_pkg::CURSOR_BITS'(pos_y_reg)) && (out_buttons_reg == last_buttons_reg))
    // An event always reports some change
    `MPCT_ASSERT_SAME(a_event_has_change, out_valid_reg, out_moved_reg || (out_changed_reg != '0))
    // A blocked packet stays in the input register
    `MPCT_ASSERT_NEXT(a_stage_holds, stage_valid_reg && !advance, stage_valid_reg)

endmodule

`default_nettype wire

/* sim/mouse_packet_cursor_tracker_tb.sv */
// Testbench for the mouse packet cursor tracker: predicted cursor events versus DUT output.
module mouse_packet_cursor_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mpct_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int LONG_HOLD = 400;
    localparam int DRAIN_CYCLES = 4;

    typedef struct packed {
        logic [BYTE_BITS-1:0] hdr;
        logic [BYTE_BITS-1:0] dx;
        logic [BYTE_BITS-1:0] dy;
    } packet_t;

    typedef struct packed {
        logic [CURSOR_BITS-1:0] x;
        logic [CURSOR_BITS-1:0] y;
        logic [BUTTON_BITS-1:0] buttons;
        logic [BUTTON_BITS-1:0] changed;
        logic                   moved;
    } cursor_event_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [COORD_BITS-1:0] cfg_data;

    mpct_packet_if packet_ch ();
    mpct_cursor_if cursor_ch ();

    mouse_packet_cursor_tracker DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .packet    (packet_ch),
        .cursor    (cursor_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Packets waiting to be sent and cursor events waiting to arrive
    packet_t packet_q[$];
    cursor_event_t cursor_events_q[$];

    // Predicted limits and tracked cursor state
    logic [COORD_BITS-1:0] limit_x;
    logic [COORD_BITS-1:0] limit_y;
    logic [COORD_BITS-1:0] track_x;
    logic [COORD_BITS-1:0] track_y;
    logic [BUTTON_BITS-1:0] track_buttons;

    // Buttons of the last well-formed packet generated
    logic [BUTTON_BITS-1:0] gen_buttons;

    int err_count;
    int idle_cycles;
    bit pkt_taken;
    bit no_idle;
    bit sink_hold_req;
    int send_gap;
    int stall_left;
    packet_t next_pkt;
    cursor_event_t want;
    cursor_event_t got;

    // Apply one packet to the tracked cursor; return 1 when it yields an event
    function automatic bit track_packet(input packet_t p, output cursor_event_t ev);
        int dx;
        int dy;
        int nx;
        int ny;
        logic [BUTTON_BITS-1:0] btn;
        ev = '0;
        if ((p.hdr & HDR_CHECK_MASK) != HDR_CHECK_VALUE)
            return 1'b0;
        dx = p.dx;
        if (p.hdr[HDR_SIGN_X_BIT])
            dx -= 256;
        dy = p.dy;
        if (p.hdr[HDR_SIGN_Y_BIT])
            dy -= 256;
        btn = p.hdr[BUTTON_BITS-1:0];
        nx = int'(track_x) + dx;
        ny = int'(track_y) - dy;
        if (nx < 0)
            nx = 0;
        else if (nx > int'(limit_x))
            nx = limit_x;
        if (ny < 0)
            ny = 0;
        else if (ny > int'(limit_y))
            ny = limit_y;
        ev.moved = (nx != int'(track_x)) || (ny != int'(track_y));
        if (!ev.moved && btn == track_buttons)
            return 1'b0;
        ev.x = CURSOR_BITS'(nx);
        ev.y = CURSOR_BITS'(ny);
        ev.buttons = btn;
        ev.changed = btn ^ track_buttons;
        track_x = COORD_BITS'(nx);
        track_y = COORD_BITS'(ny);
        track_buttons = btn;
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_val,
                                        input int unsigned act_val);
        if (exp_val != act_val)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            err_count++;
        end
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        if (r < 93)
            return $urandom_range(3, 6);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [COORD_BITS-1:0] pick_limit();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return COORD_BITS'($urandom_range(1, 40));
            default: return COORD_BITS'($urandom_range(0, (1 << COORD_BITS) - 1));
        endcase
    endfunction

    function automatic void queue_packet(input logic [BYTE_BITS-1:0] h,
                                         input logic [BYTE_BITS-1:0] x,
                                         input logic [BYTE_BITS-1:0] y);
        packet_t p;
        p.hdr = h;
        p.dx = x;
        p.dy = y;
        packet_q.push_back(p);
    endfunction

    function automatic logic [DELTA_BITS-1:0] random_delta();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return DELTA_BITS'(int'($urandom_range(0, 8)) - 4);
            2: return DELTA_BITS'($urandom);
            default: return $urandom_range(0, 1) ? DELTA_BITS'(255) : DELTA_BITS'(-256);
        endcase
    endfunction

    // Queue a well-formed packet with random content, or raw noise
    function automatic void queue_random(input int noise_pct);
        logic [DELTA_BITS-1:0] dx;
        logic [DELTA_BITS-1:0] dy;
        if ($urandom_range(0, 99) < noise_pct)
        begin
            queue_packet(BYTE_BITS'($urandom), BYTE_BITS'($urandom), BYTE_BITS'($urandom));
            return;
        end
        if ($urandom_range(0, 99) < 25)
            gen_buttons = BUTTON_BITS'($urandom);
        dx = random_delta();
        dy = random_delta();
        queue_packet({2'b00, dy[BYTE_BITS], dx[BYTE_BITS], 1'b1, gen_buttons},
                     dx[BYTE_BITS-1:0], dy[BYTE_BITS-1:0]);
    endfunction

    // Wait until every packet is sent and every event has arrived, then let the pipe drain
    task automatic wait_idle();
        while (packet_q.size() != 0 || packet_ch.valid || cursor_events_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input cfg_reg_t idx, input logic [COORD_BITS-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == REG_MAX_X)
            limit_x = val;
        else
            limit_y = val;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Packet driver: hold the item until taken, then advance or idle
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            packet_ch.valid <= 1'b0;
            send_gap = 0;
        end
        else if (!packet_ch.valid || pkt_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                packet_ch.valid <= 1'b0;
            end
            else if (packet_q.size() > 0)
            begin
                next_pkt = packet_q.pop_front();
                packet_ch.header_byte <= next_pkt.hdr;
                packet_ch.delta_x_byte <= next_pkt.dx;
                packet_ch.delta_y_byte <= next_pkt.dy;
                packet_ch.valid <= 1'b1;
                if (!no_idle && $urandom_range(0, 99) < 35)
                    send_gap = pick_gap();
            end
            else
                packet_ch.valid <= 1'b0;
        end
    end

    // Packet acceptance: predict the event of each item taken
    always @(posedge clk)
    begin
        pkt_taken = rst_n && packet_ch.valid && packet_ch.ready;
        if (pkt_taken)
        begin
            if (track_packet({packet_ch.header_byte, packet_ch.delta_x_byte,
                              packet_ch.delta_y_byte}, want))
                cursor_events_q.push_back(want);
        end
    end

    // Event receiver: random stalls plus the long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            cursor_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            cursor_ch.ready <= 1'b0;
        end
        else if (sink_hold_req)
        begin
            sink_hold_req = 1'b0;
            stall_left = LONG_HOLD - 1;
            cursor_ch.ready <= 1'b0;
        end
        else if (!no_idle && $urandom_range(0, 99) < 25)
        begin
            stall_left = pick_gap() - 1;
            cursor_ch.ready <= 1'b0;
        end
        else
            cursor_ch.ready <= 1'b1;
    end

    // Event monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cursor_ch.valid && cursor_ch.ready)
            begin
                got.x = cursor_ch.cursor_x;
                got.y = cursor_ch.cursor_y;
                got.buttons = cursor_ch.button_state;
                got.changed = cursor_ch.button_changed;
                got.moved = cursor_ch.moved;
                if (cursor_events_q.size() == 0)
                begin
                    $error("unexpected cursor event x=%0d y=%0d", got.x, got.y);
                    err_count++;
                end
                else
                begin
                    want = cursor_events_q.pop_front();
                    check_field("cursor_x", want.x, got.x);
                    check_field("cursor_y", want.y, got.y);
                    check_field("button_state", want.buttons, got.buttons);
                    check_field("button_changed", want.changed, got.changed);
                    check_field("moved", want.moved, got.moved);
                end
            end
            if ((cursor_ch.valid && cursor_ch.ready) || (packet_ch.valid && packet_ch.ready))
                idle_cycles = 0;
            else if (++idle_cycles >= IDLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Stimulus
    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_MAX_X;
        cfg_data = '0;
        packet_ch.valid = 1'b0;
        packet_ch.header_byte = '0;
        packet_ch.delta_x_byte = '0;
        packet_ch.delta_y_byte = '0;
        cursor_ch.ready = 1'b0;
        err_count = 0;
        idle_cycles = 0;
        no_idle = 1'b0;
        sink_hold_req = 1'b0;
        gen_buttons = '0;
        limit_x = MAX_X_RESET;
        limit_y = MAX_Y_RESET;
        track_x = POS_X_RESET;
        track_y = POS_Y_RESET;
        track_buttons = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: no change, bad headers, buttons, delta extremes, walls
        queue_packet(8'h08, 8'h00, 8'h00);
        queue_packet(8'hC8, 8'h05, 8'h05);
        queue_packet(8'h48, 8'h05, 8'h05);
        queue_packet(8'h88, 8'h05, 8'h05);
        queue_packet(8'h07, 8'h05, 8'h05);
        queue_packet(8'hFF, 8'hFF, 8'hFF);
        queue_packet(8'h09, 8'h00, 8'h00);
        queue_packet(8'h0F, 8'h00, 8'h00);
        queue_packet(8'h08, 8'h00, 8'h00);
        queue_packet(8'h08, 8'h7F, 8'h7F);
        queue_packet(8'h38, 8'h80, 8'h80);
        queue_packet(8'h18, 8'h00, 8'h01);
        queue_packet(8'h28, 8'hFF, 8'h00);
        repeat (5) queue_packet(8'h0A, 8'hFF, 8'h7F);
        repeat (5) queue_packet(8'h3C, 8'h00, 8'h00);
        wait_idle();

        // Lower both limits below the cursor: the next packet clamps it in
        write_limit(REG_MAX_X, '0);
        write_limit(REG_MAX_Y, '0);
        queue_packet(8'h0C, 8'h00, 8'h00);
        queue_packet(8'h0C, 8'h10, 8'h10);
        wait_idle();

        // Random phases under different limits
        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph)
                0:
                begin
                    write_limit(REG_MAX_X, '1);
                    write_limit(REG_MAX_Y, '1);
                    repeat (18) queue_packet(8'h28, 8'hFF, 8'h01);
                    repeat (90) queue_random(12);
                end
                2:
                begin
                    // Hold the receiver off while packets keep coming
                    write_limit(REG_MAX_X, MAX_X_RESET);
                    write_limit(REG_MAX_Y, MAX_Y_RESET);
                    @(posedge clk);
                    sink_hold_req = 1'b1;
                    for (int i = 0; i < 60; i++)
                        queue_packet({5'b00001, BUTTON_BITS'(i)}, BYTE_BITS'($urandom),
                                     BYTE_BITS'($urandom));
                end
                3:
                begin
                    write_limit(REG_MAX_X, MAX_X_RESET);
                    write_limit(REG_MAX_Y, MAX_Y_RESET);
                    no_idle = 1'b1;
                    repeat (100) queue_random(12);
                end
                default:
                begin
                    write_limit(REG_MAX_X, pick_limit());
                    write_limit(REG_MAX_Y, pick_limit());
                    repeat (105) queue_random(12);
                end
            endcase
            wait_idle();
            no_idle = 1'b0;
        end

        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
